// ----- sv/matc_pkg.sv -----
// Shared constants, action codes and result descriptor for the arrival-time capture block.
// No dependencies.
package matc_pkg;

  localparam int NUM_CH = 6;
  localparam int CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int CNT_W  = $clog2(NUM_CH + 1);

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_TRIGGER = 3'd1;
  localparam logic [2:0] ACT_DONE    = 3'd2;
  localparam logic [2:0] ACT_RESET   = 3'd3;
  localparam logic [2:0] ACT_CAPTURE = 3'd4;
  localparam logic [2:0] ACT_WRAP    = 3'd5;

  localparam logic [1:0] REG_ARM_DELAY = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_MAX_SUCC  = 2'd2;

  localparam logic [15:0] ARM_DELAY_RST = 16'd2000;
  localparam logic [15:0] TIMEOUT_RST   = 16'd50;
  localparam logic [7:0]  MAX_SUCC_RST  = 8'd3;
  localparam logic [7:0]  SUCC_SAT      = 8'd255;

  typedef struct packed {
    logic       emit;
    logic       ready_line;
    logic [1:0] fsm_state;
    logic [7:0] success_total;
    logic       timer_clear;
  } res_t;

endpackage

// ----- sv/multichannel_arrival_time_capture.sv -----
// A transaction's result is registered in the output register, or in the skid while that register is busy.
// Throughput: one input transaction per cycle while in_stall is low; a poll that completes a set yields
// one record per channel, one per cycle while out_stall is low, and holds off input until its last record goes.
// A two-entry output queue (output register plus skid) parts input from output stall.
// Reset (rst_n low, synchronous) restores register defaults and clears all control state.
// Top level of the arrival-time capture block; depends on matc_pkg.
module multichannel_arrival_time_capture (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_channel,
  input  logic [31:0] in_capture_value,
  input  logic        in_wrap_pending,
  input  logic        in_trigger_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_valid,
  output logic [2:0]  out_record_channel,
  output logic [31:0] out_overflow_word,
  output logic [31:0] out_tick_word,
  output logic        out_last,
  output logic        out_ready_line,
  output logic [1:0]  out_fsm_state,
  output logic [7:0]  out_success_total,
  output logic        out_timer_clear
);
  import matc_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ARM   = 2'd1,
    MODE_CAP   = 2'd2,
    MODE_READY = 2'd3
  } mode_t;

  logic [15:0] arm_delay_r, timeout_r;
  logic [7:0]  max_succ_r;

  mode_t            mode_r, mode_nxt;
  logic             trig_seen_r, trig_seen_nxt;
  logic             done_seen_r, done_seen_nxt;
  logic             rst_seen_r, rst_seen_nxt;
  logic [31:0]      ms_now_r, ms_now_nxt;
  logic [31:0]      delay_start_r, delay_start_nxt;
  logic             delay_run_r, delay_run_nxt;
  logic [31:0]      first_time_r, first_time_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [NUM_CH-1:0] mask_r, mask_nxt;
  logic [31:0]      wrap_cnt_r, wrap_cnt_nxt;
  logic [7:0]       reads_r, reads_nxt;
  logic             ready_line_r, ready_line_nxt;
  logic [31:0]      stamp_hi_r [NUM_CH];
  logic [31:0]      stamp_lo_r [NUM_CH];

  logic             out_valid_r, sk_valid_r;
  res_t             out_d_r, sk_d_r, res_new;
  logic [CH_W-1:0]  idx_r;

  logic             cfg_wr, in_acc, out_take, out_last_c, out_fin, out_free;
  logic             cap_ok, emit_c, clr_c;
  logic [CH_W-1:0]  ch_idx;
  logic [31:0]      ms_inc;
  logic [7:0]       reads_inc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_ARM_DELAY: prdata = {16'd0, arm_delay_r};
      REG_TIMEOUT:   prdata = {16'd0, timeout_r};
      REG_MAX_SUCC:  prdata = {24'd0, max_succ_r};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_delay_r <= ARM_DELAY_RST;
      timeout_r   <= TIMEOUT_RST;
      max_succ_r  <= MAX_SUCC_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ARM_DELAY: arm_delay_r <= pwdata[15:0];
        REG_TIMEOUT:   timeout_r   <= pwdata[15:0];
        REG_MAX_SUCC:  max_succ_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign out_last_c = !out_d_r.emit || (idx_r == CH_W'(NUM_CH - 1));
  assign out_take   = out_valid_r && !out_stall;
  assign out_fin    = out_take && out_last_c;
  assign out_free   = !out_valid_r || out_fin;
  assign in_stall   = sk_valid_r || (out_valid_r && out_d_r.emit && !out_fin);
  assign in_acc     = in_valid && !in_stall;

  assign ch_idx    = CH_W'(in_channel);
  assign cap_ok    = (mode_r == MODE_CAP) && (32'(in_channel) < 32'(NUM_CH)) && !mask_r[ch_idx];
  assign ms_inc    = ms_now_r + 32'd1;
  assign reads_inc = reads_r + ((reads_r != SUCC_SAT) ? 8'd1 : 8'd0);

  always_comb begin
    mode_nxt        = mode_r;
    trig_seen_nxt   = trig_seen_r;
    done_seen_nxt   = done_seen_r;
    rst_seen_nxt    = rst_seen_r;
    ms_now_nxt      = ms_now_r;
    delay_start_nxt = delay_start_r;
    delay_run_nxt   = delay_run_r;
    first_time_nxt  = first_time_r;
    total_nxt       = total_r;
    mask_nxt        = mask_r;
    wrap_cnt_nxt    = wrap_cnt_r;
    reads_nxt       = reads_r;
    ready_line_nxt  = ready_line_r;
    emit_c          = 1'b0;
    clr_c           = 1'b0;
    case (in_action)
      ACT_TICK: begin
        ms_now_nxt = ms_inc;
        if (rst_seen_r) begin
          mask_nxt       = '0;
          total_nxt      = '0;
          first_time_nxt = 32'd0;
          reads_nxt      = 8'd0;
          wrap_cnt_nxt   = 32'd0;
          ready_line_nxt = 1'b0;
          delay_run_nxt  = 1'b0;
          mode_nxt       = MODE_IDLE;
          trig_seen_nxt  = 1'b0;
          done_seen_nxt  = 1'b0;
          rst_seen_nxt   = 1'b0;
          clr_c          = 1'b1;
        end else begin
          if (done_seen_r) begin
            done_seen_nxt = 1'b0;
            if (mode_r == MODE_READY) begin
              ready_line_nxt = 1'b0;
              reads_nxt      = reads_inc;
              mask_nxt       = '0;
              total_nxt      = '0;
              first_time_nxt = 32'd0;
              mode_nxt       = (reads_inc >= max_succ_r) ? MODE_IDLE : MODE_CAP;
            end
          end
          case (mode_nxt)
            MODE_IDLE: begin
              if (trig_seen_r) begin
                trig_seen_nxt   = 1'b0;
                delay_start_nxt = ms_inc;
                delay_run_nxt   = 1'b1;
                mode_nxt        = MODE_ARM;
              end
            end
            MODE_ARM: begin
              if (!in_trigger_level) begin
                delay_run_nxt = 1'b0;
                mode_nxt      = MODE_IDLE;
              end else if (delay_run_r &&
                           (ms_inc - delay_start_r) >= {16'd0, arm_delay_r}) begin
                delay_run_nxt  = 1'b0;
                mask_nxt       = '0;
                total_nxt      = '0;
                first_time_nxt = 32'd0;
                mode_nxt       = MODE_CAP;
              end
            end
            MODE_CAP: begin
              if (!in_trigger_level) begin
                mask_nxt       = '0;
                total_nxt      = '0;
                first_time_nxt = 32'd0;
                mode_nxt       = MODE_IDLE;
              end else if (total_nxt == CNT_W'(NUM_CH)) begin
                ready_line_nxt = 1'b1;
                mode_nxt       = MODE_READY;
                emit_c         = 1'b1;
              end else if ((total_nxt != '0) &&
                           (ms_inc - first_time_nxt) >= {16'd0, timeout_r}) begin
                mask_nxt       = '0;
                total_nxt      = '0;
                first_time_nxt = 32'd0;
              end
            end
            default: ;
          endcase
        end
      end
      ACT_TRIGGER: trig_seen_nxt = 1'b1;
      ACT_DONE:    done_seen_nxt = 1'b1;
      ACT_RESET:   rst_seen_nxt  = 1'b1;
      ACT_CAPTURE: begin
        if (cap_ok) begin
          if (total_r == '0) begin
            first_time_nxt = ms_now_r;
          end
          mask_nxt[ch_idx] = 1'b1;
          total_nxt        = total_r + CNT_W'(1);
        end
      end
      ACT_WRAP:    wrap_cnt_nxt = wrap_cnt_r + 32'd1;
      default: ;
    endcase
  end

  always_comb begin
    res_new.emit          = emit_c;
    res_new.ready_line    = ready_line_nxt;
    res_new.fsm_state     = mode_nxt;
    res_new.success_total = reads_nxt;
    res_new.timer_clear   = clr_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      trig_seen_r   <= 1'b0;
      done_seen_r   <= 1'b0;
      rst_seen_r    <= 1'b0;
      ms_now_r      <= 32'd0;
      delay_start_r <= 32'd0;
      delay_run_r   <= 1'b0;
      first_time_r  <= 32'd0;
      total_r       <= '0;
      mask_r        <= '0;
      wrap_cnt_r    <= 32'd0;
      reads_r       <= 8'd0;
      ready_line_r  <= 1'b0;
    end else if (in_acc) begin
      mode_r        <= mode_nxt;
      trig_seen_r   <= trig_seen_nxt;
      done_seen_r   <= done_seen_nxt;
      rst_seen_r    <= rst_seen_nxt;
      ms_now_r      <= ms_now_nxt;
      delay_start_r <= delay_start_nxt;
      delay_run_r   <= delay_run_nxt;
      first_time_r  <= first_time_nxt;
      total_r       <= total_nxt;
      mask_r        <= mask_nxt;
      wrap_cnt_r    <= wrap_cnt_nxt;
      reads_r       <= reads_nxt;
      ready_line_r  <= ready_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_action == ACT_CAPTURE) && cap_ok) begin
      stamp_hi_r[ch_idx] <= wrap_cnt_r + 32'(in_wrap_pending);
      stamp_lo_r[ch_idx] <= in_capture_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
      idx_r       <= '0;
    end else if (out_free) begin
      idx_r <= '0;
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else begin
      if (out_take) begin
        idx_r <= idx_r + CH_W'(1);
      end
      if (in_acc) begin
        sk_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= sk_valid_r ? sk_d_r : res_new;
    end else if (in_acc) begin
      sk_d_r <= res_new;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_valid   = out_d_r.emit;
  assign out_record_channel = out_d_r.emit ? 3'(idx_r) : 3'd0;
  assign out_overflow_word  = out_d_r.emit ? stamp_hi_r[idx_r] : 32'd0;
  assign out_tick_word      = out_d_r.emit ? stamp_lo_r[idx_r] : 32'd0;
  assign out_last           = out_last_c;
  assign out_ready_line     = out_d_r.ready_line;
  assign out_fsm_state      = out_d_r.fsm_state;
  assign out_success_total  = out_d_r.success_total;
  assign out_timer_clear    = out_d_r.timer_clear;

endmodule

// ----- sv/matc_checker.sv -----
// Port-level checker for the arrival-time capture block, bound to its top level.
// Depends on matc_pkg.
module matc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_valid,
  input logic [2:0]  out_record_channel,
  input logic        out_last,
  input logic        out_ready_line,
  input logic [7:0]  out_success_total,
  input logic        out_timer_clear
);
  import matc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_record_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_valid && !out_last && !out_stall |=>
      out_valid && out_record_valid &&
      (out_record_channel == $past(out_record_channel) + 3'd1))
    else $error("record burst broken");

  a_record_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_valid |-> out_ready_line)
    else $error("record without data ready");

  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_valid |-> out_last && (out_record_channel == 3'd0))
    else $error("malformed status result");

  a_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timer_clear |->
      (out_success_total == 8'd0) && !out_ready_line && !out_record_valid &&
      (32'(NUM_CH) > 32'd0))
    else $error("timer clear without full reset");

endmodule

bind multichannel_arrival_time_capture matc_checker u_matc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_record_valid   (out_record_valid),
  .out_record_channel (out_record_channel),
  .out_last           (out_last),
  .out_ready_line     (out_ready_line),
  .out_success_total  (out_success_total),
  .out_timer_clear    (out_timer_clear)
);
